FILE: hdl/asba_pkg.sv
// Shared types and constants for the atlas shelf block allocator.
package asba_pkg;

    localparam int MAX_ATLAS_SIZE = 2048;
    localparam int IDX_W          = $clog2(MAX_ATLAS_SIZE);
    localparam int SIZE_W         = 12;
    localparam int POS_W          = 11;

    localparam logic [SIZE_W-1:0] ATLAS_MAX  = SIZE_W'(MAX_ATLAS_SIZE);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2048);

    localparam logic CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic CFG_ATLAS_HEIGHT = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef struct packed {
        logic              used;
        logic [POS_W-1:0]  top;
        logic [SIZE_W-1:0] fill;
    } t_shelf;

    localparam int SHELF_W = $bits(t_shelf);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_CLEAR,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/atlas_shelf_block_allocator.sv
// Shelf allocator top level: shelf memory, sequencer and result register.
//
// One shelf per block height lives in a 2048-entry memory (used flag, shelf y,
// fill x). An allocate beat passes through the look and output states when the
// shelf for its height has room or a new shelf can open; when the atlas has no
// vertical room left, the block scans the taller shelves one per cycle through
// the single memory read port until a fit is found or the atlas height is
// reached. A refused request goes straight to the output state. A clear beat
// walks the whole shelf memory, one entry per cycle, and answers at its end.
// After reset the same clearing pass runs before the first beat is accepted;
// configuration writes are taken at any time. The result register lets the
// next beat be accepted while a result still waits downstream.
module atlas_shelf_block_allocator
    import asba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    // request
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_mode,
    input  logic [SIZE_W-1:0] i_block_width,
    input  logic [SIZE_W-1:0] i_block_height,
    // result
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_granted,
    output logic [POS_W-1:0]  o_pos_x,
    output logic [POS_W-1:0]  o_pos_y
);

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_atlas_width, r_atlas_height;
    logic [SIZE_W-1:0]  r_bw, n_bw;
    logic [SIZE_W-1:0]  r_bh, n_bh;
    logic [SIZE_W-1:0]  r_chk, n_chk;
    logic [SIZE_W-1:0]  r_next_y, n_next_y;
    logic [IDX_W-1:0]   r_clr_cnt, n_clr_cnt;
    logic               r_clr_reply, n_clr_reply;
    logic               r_res_granted, n_res_granted;
    logic [POS_W-1:0]   r_res_x, n_res_x;
    logic [POS_W-1:0]   r_res_y, n_res_y;
    logic               r_out_valid;
    logic               r_granted;
    logic [POS_W-1:0]   r_pos_x, r_pos_y;

    logic [SIZE_W-1:0]  w_aw, w_ah;
    logic               w_accept, w_bad, w_out_free;
    logic               w_hit, w_room, w_scan_end;
    logic [SIZE_W-1:0]  w_next_chk;
    logic [SIZE_W:0]    w_fill_sum;
    t_shelf             w_rd_entry, w_wr_entry;
    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr, w_rd_addr;
    logic [SHELF_W-1:0] w_rd_data;

    // oversized register values act as the maximum atlas size
    assign w_aw = (r_atlas_width  > ATLAS_MAX) ? ATLAS_MAX : r_atlas_width;
    assign w_ah = (r_atlas_height > ATLAS_MAX) ? ATLAS_MAX : r_atlas_height;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign w_accept    = i_valid && (r_state == ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_stall;

    assign w_bad = (i_block_width == '0) || (i_block_height == '0)
                || (i_block_width > w_aw) || (i_block_height >= w_ah);

    assign w_rd_entry = t_shelf'(w_rd_data);
    assign w_fill_sum = {1'b0, w_rd_entry.fill} + {1'b0, r_bw};
    assign w_hit      = w_rd_entry.used && (w_fill_sum <= {1'b0, w_aw});
    assign w_room     = ({1'b0, r_next_y} + {1'b0, r_bh}) <= {1'b0, w_ah};
    assign w_next_chk = (r_state == ST_LOOK) ? (r_bh + 1'b1) : (r_chk + 1'b1);
    assign w_scan_end = (w_next_chk >= w_ah);

    asba_ram #(
        .WIDTH (SHELF_W),
        .DEPTH (MAX_ATLAS_SIZE)
    ) u_shelf_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode == MODE_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (w_bad) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                if (w_hit || w_room || w_scan_end) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit || w_scan_end) begin
                    n_state = ST_OUT;
                end
            end
            ST_CLEAR: begin
                if (r_clr_cnt == '1) begin
                    n_state = r_clr_reply ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_bw          = r_bw;
        n_bh          = r_bh;
        n_chk         = r_chk;
        n_next_y      = r_next_y;
        n_clr_cnt     = r_clr_cnt;
        n_clr_reply   = r_clr_reply;
        n_res_granted = r_res_granted;
        n_res_x       = r_res_x;
        n_res_y       = r_res_y;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_bh[IDX_W-1:0];
        w_wr_entry    = w_rd_entry;
        w_rd_addr     = w_next_chk[IDX_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                w_rd_addr = i_block_height[IDX_W-1:0];
                if (w_accept) begin
                    n_bw          = i_block_width;
                    n_bh          = i_block_height;
                    n_res_granted = 1'b0;
                    n_res_x       = '0;
                    n_res_y       = '0;
                    if (i_mode == MODE_CLEAR) begin
                        n_next_y    = '0;
                        n_clr_cnt   = '0;
                        n_clr_reply = 1'b1;
                    end
                end
            end
            ST_LOOK: begin
                n_chk = w_next_chk;
                if (w_hit) begin
                    w_wr_en         = 1'b1;
                    w_wr_entry.fill = w_fill_sum[SIZE_W-1:0];
                    n_res_granted   = 1'b1;
                    n_res_x         = w_rd_entry.fill[POS_W-1:0];
                    n_res_y         = w_rd_entry.top;
                end else if (w_room) begin
                    // open a fresh shelf for this height, abandon the old one
                    w_wr_en         = 1'b1;
                    w_wr_entry.used = 1'b1;
                    w_wr_entry.top  = r_next_y[POS_W-1:0];
                    w_wr_entry.fill = r_bw;
                    n_next_y        = r_next_y + r_bh;
                    n_res_granted   = 1'b1;
                    n_res_x         = '0;
                    n_res_y         = r_next_y[POS_W-1:0];
                end
            end
            ST_SCAN: begin
                n_chk = w_next_chk;
                if (w_hit) begin
                    w_wr_en         = 1'b1;
                    w_wr_addr       = r_chk[IDX_W-1:0];
                    w_wr_entry.fill = w_fill_sum[SIZE_W-1:0];
                    n_res_granted   = 1'b1;
                    n_res_x         = w_rd_entry.fill[POS_W-1:0];
                    n_res_y         = w_rd_entry.top;
                end
            end
            ST_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_cnt;
                w_wr_entry = '0;
                n_clr_cnt  = r_clr_cnt + 1'b1;
            end
            ST_OUT: begin
                n_clr_reply = 1'b0;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_cnt      <= '0;
            r_clr_reply    <= 1'b0;
            r_next_y       <= '0;
            r_atlas_width  <= SIZE_RESET;
            r_atlas_height <= SIZE_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_reply <= n_clr_reply;
            r_next_y    <= n_next_y;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ATLAS_WIDTH:  r_atlas_width  <= i_cfg_data;
                    CFG_ATLAS_HEIGHT: r_atlas_height <= i_cfg_data;
                    default:          r_atlas_width  <= r_atlas_width;
                endcase
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bw          <= n_bw;
        r_bh          <= n_bh;
        r_chk         <= n_chk;
        r_res_granted <= n_res_granted;
        r_res_x       <= n_res_x;
        r_res_y       <= n_res_y;
        if (r_state == ST_OUT && w_out_free) begin
            r_granted <= r_res_granted;
            r_pos_x   <= r_res_x;
            r_pos_y   <= r_res_y;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_granted = r_granted;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;

endmodule

FILE: hdl/asba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the atlas shelf block allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import asba_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } t_request;

    typedef struct packed {
        logic             granted;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_place;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index    = CFG_ATLAS_WIDTH;
    logic [SIZE_W-1:0] i_cfg_data     = '0;
    logic              i_valid        = 1'b0;
    logic              o_stall;
    logic              i_mode         = MODE_ALLOC;
    logic [SIZE_W-1:0] i_block_width  = '0;
    logic [SIZE_W-1:0] i_block_height = '0;
    logic              o_valid;
    logic              i_stall        = 1'b0;
    logic              o_granted;
    logic [POS_W-1:0]  o_pos_x;
    logic [POS_W-1:0]  o_pos_y;

    // mirror of the atlas registers and the shelf table
    logic [SIZE_W-1:0] atlas_w = SIZE_RESET;
    logic [SIZE_W-1:0] atlas_h = SIZE_RESET;
    bit                shelf_used [MAX_ATLAS_SIZE];
    bit [POS_W-1:0]    shelf_top  [MAX_ATLAS_SIZE];
    bit [SIZE_W-1:0]   shelf_fill [MAX_ATLAS_SIZE];
    int                free_y;

    t_request request_backlog[$];
    t_place   placement_due[$];
    int       items_queued;
    int       items_answered;
    int       mismatches;
    int       idle_cycles;
    int       req_gap;
    int       res_wait;
    bit       req_taken;
    bit       res_taken;
    bit       quiet;

    atlas_shelf_block_allocator DUT (.*);

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_size(logic [SIZE_W-1:0] v);
        return (int'(v) > MAX_ATLAS_SIZE) ? MAX_ATLAS_SIZE : int'(v);
    endfunction

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Work out the placement for one request and update the shelf table.
    function automatic t_place place_block(t_request rq);
        t_place res;
        int     aw;
        int     ah;
        int     sel;
        bit     fits;
        res  = '0;
        fits = 1'b0;
        aw   = eff_size(atlas_w);
        ah   = eff_size(atlas_h);
        if (rq.mode == MODE_CLEAR) begin
            for (int k = 0; k < MAX_ATLAS_SIZE; k++) begin
                shelf_used[k] = 1'b0;
                shelf_top[k]  = '0;
                shelf_fill[k] = '0;
            end
            free_y = 0;
            return res;
        end
        if (rq.width == 0 || rq.height == 0 || int'(rq.width) > aw || int'(rq.height) >= ah)
            return res;
        sel = int'(rq.height);
        if (!shelf_used[sel] || int'(shelf_fill[sel]) + int'(rq.width) > aw) begin
            if (free_y + int'(rq.height) <= ah) begin
                shelf_used[sel] = 1'b1;
                shelf_top[sel]  = POS_W'(free_y);
                shelf_fill[sel] = '0;
                free_y += int'(rq.height);
                fits = 1'b1;
            end else begin
                // no vertical room: take the first taller shelf with space
                for (int h = int'(rq.height); h < ah && !fits; h++) begin
                    if (shelf_used[h] && int'(shelf_fill[h]) + int'(rq.width) <= aw) begin
                        sel  = h;
                        fits = 1'b1;
                    end
                end
            end
        end else begin
            fits = 1'b1;
        end
        if (fits) begin
            res.granted = 1'b1;
            res.x       = shelf_fill[sel][POS_W-1:0];
            res.y       = shelf_top[sel];
            shelf_fill[sel] = shelf_fill[sel] + rq.width;
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_item(logic mode, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        t_request rq;
        rq.mode   = mode;
        rq.width  = w;
        rq.height = h;
        request_backlog.push_back(rq);
        items_queued++;
    endtask

    task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_ATLAS_WIDTH)
            atlas_w = val;
        else
            atlas_h = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (items_answered != items_queued);
    endtask

    // request driver: hold a beat until taken, then idle for the drawn gap
    always @(negedge i_clk) begin : drive_requests
        t_request rq;
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (req_gap > 0) begin
                i_valid <= 1'b0;
                req_gap <= req_gap - 1;
            end else if (request_backlog.size() > 0) begin
                rq = request_backlog.pop_front();
                i_valid        <= 1'b1;
                i_mode         <= rq.mode;
                i_block_width  <= rq.width;
                i_block_height <= rq.height;
                req_gap        <= draw_wait();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side: after each taken beat, stall for the drawn number of cycles
    always @(negedge i_clk) begin : drive_stall
        int wait_now;
        wait_now = res_taken ? draw_wait() : res_wait;
        if (wait_now > 0) begin
            i_stall  <= 1'b1;
            res_wait <= wait_now - 1;
        end else begin
            i_stall  <= 1'b0;
            res_wait <= 0;
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_request rq;
        t_place   want;
        bit       req_beat;
        bit       res_beat;
        req_beat  = i_rst_n && i_valid && !o_stall;
        res_beat  = i_rst_n && o_valid === 1'b1 && !i_stall;
        req_taken <= req_beat;
        res_taken <= res_beat;
        if (req_beat) begin
            rq.mode   = i_mode;
            rq.width  = i_block_width;
            rq.height = i_block_height;
            placement_due.push_back(place_block(rq));
        end
        if (res_beat) begin
            if (placement_due.size() == 0) begin
                flag_mismatch("result with nothing pending, granted", o_granted, 0);
            end else begin
                want = placement_due.pop_front();
                if (o_granted !== want.granted)
                    flag_mismatch("granted", o_granted, want.granted);
                if (o_pos_x !== want.x)
                    flag_mismatch("pos_x", o_pos_x, want.x);
                if (o_pos_y !== want.y)
                    flag_mismatch("pos_y", o_pos_y, want.y);
                items_answered++;
            end
        end
        if (req_beat || res_beat || (i_cfg_valid && o_cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("atlas_shelf_block_allocator test failed");
        $finish;
    end

    initial begin : stimulus
        int aw;
        int ah;
        int wmax;
        int hmax;
        int n;
        int pick;
        int random_items;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset-size atlas: refusals, shelf reuse, new shelves, fallback scan
        add_item(MODE_CLEAR, 12'd9, 12'd4);
        add_item(MODE_ALLOC, 12'd0, 12'd5);
        add_item(MODE_ALLOC, 12'd5, 12'd0);
        add_item(MODE_ALLOC, 12'd2049, 12'd3);
        add_item(MODE_ALLOC, 12'd4095, 12'd4095);
        add_item(MODE_ALLOC, 12'd1, 12'd2048);
        add_item(MODE_ALLOC, 12'd2048, 12'd1);
        add_item(MODE_ALLOC, 12'd1, 12'd1);
        add_item(MODE_ALLOC, 12'd1, 12'd2047);
        add_item(MODE_ALLOC, 12'd100, 12'd2045);
        add_item(MODE_ALLOC, 12'd10, 12'd1);
        add_item(MODE_ALLOC, 12'd2048, 12'd1);
        add_item(MODE_ALLOC, 12'd50, 12'd3);
        add_item(MODE_ALLOC, 12'd1948, 12'd10);
        add_item(MODE_ALLOC, 12'd1898, 12'd7);
        add_item(MODE_CLEAR, 12'd4095, 12'd4095);
        add_item(MODE_ALLOC, 12'd7, 12'd9);
        wait_drained();

        // oversized registers clamp to the full atlas
        write_reg(CFG_ATLAS_WIDTH, 12'd4095);
        write_reg(CFG_ATLAS_HEIGHT, 12'd4095);
        @(posedge i_clk);
        add_item(MODE_ALLOC, 12'd2048, 12'd5);
        add_item(MODE_ALLOC, 12'd1, 12'd5);
        wait_drained();

        write_reg(CFG_ATLAS_WIDTH, 12'd0);
        @(posedge i_clk);
        add_item(MODE_ALLOC, 12'd1, 12'd1);
        wait_drained();

        write_reg(CFG_ATLAS_WIDTH, 12'd2048);
        write_reg(CFG_ATLAS_HEIGHT, 12'd0);
        @(posedge i_clk);
        add_item(MODE_ALLOC, 12'd1, 12'd1);
        wait_drained();

        write_reg(CFG_ATLAS_WIDTH, 12'd1);
        write_reg(CFG_ATLAS_HEIGHT, 12'd1);
        @(posedge i_clk);
        add_item(MODE_ALLOC, 12'd1, 12'd1);
        wait_drained();

        // shrink without clearing: overfull shelves count as full
        write_reg(CFG_ATLAS_WIDTH, 12'd4);
        write_reg(CFG_ATLAS_HEIGHT, 12'd16);
        @(posedge i_clk);
        add_item(MODE_ALLOC, 12'd3, 12'd5);
        add_item(MODE_ALLOC, 12'd1, 12'd9);
        add_item(MODE_ALLOC, 12'd1, 12'd2);
        wait_drained();

        random_items = 0;
        while (random_items < 360) begin
            case ($urandom_range(0, 9))
                0: begin
                    aw = 2048;
                    ah = 2048;
                end
                1: begin
                    aw = $urandom_range(0, 4095);
                    ah = $urandom_range(0, 4095);
                end
                default: begin
                    aw = $urandom_range(8, 256);
                    ah = $urandom_range(8, 128);
                end
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_ATLAS_WIDTH, SIZE_W'(aw));
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_ATLAS_HEIGHT, SIZE_W'(ah));
            @(posedge i_clk);
            quiet = ($urandom_range(0, 3) == 0);
            wmax  = eff_size(atlas_w);
            hmax  = eff_size(atlas_h) - 1;
            if (wmax < 1)
                wmax = 1;
            if (hmax < 1)
                hmax = 1;
            if ($urandom_range(0, 2) == 0)
                add_item(MODE_CLEAR, SIZE_W'($urandom), SIZE_W'($urandom));
            n = $urandom_range(30, 60);
            repeat (n) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    add_item(MODE_CLEAR, SIZE_W'($urandom), SIZE_W'($urandom));
                end else if (pick < 12) begin
                    add_item(MODE_ALLOC, SIZE_W'($urandom_range(0, 4095)),
                             SIZE_W'($urandom_range(0, 4095)));
                end else if (pick < 28) begin
                    add_item(MODE_ALLOC, SIZE_W'($urandom_range(1, wmax)),
                             SIZE_W'($urandom_range(1, hmax)));
                end else begin
                    // few heights, so shelves get shared and the atlas fills up
                    add_item(MODE_ALLOC, SIZE_W'($urandom_range(1, (wmax + 1) / 2)),
                             SIZE_W'($urandom_range(1, (hmax < 12) ? hmax : 12)));
                end
            end
            random_items += n;
            wait_drained();
        end

        repeat (60) @(negedge i_clk);
        if (placement_due.size() != 0)
            flag_mismatch("results never delivered", 0, placement_due.size());
        if (mismatches == 0)
            $display("atlas_shelf_block_allocator test passed");
        else
            $display("atlas_shelf_block_allocator test failed");
        $finish;
    end

endmodule
